>>> rtl/fh64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fh64_pkg: shared types and constants of the streaming fasthash64 block
// Holds the transaction payload structs, the datapath command and status
// structs, and the hash constants.
// ----------------------------------------------------------------------------
package fh64_pkg;

	localparam int LEN_FIELD_W     = 32;
	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [63:0] HASH_MUL = 64'h8803_55f2_1e6d_1965;
	localparam logic [63:0] MIX_MUL  = 64'h2127_599b_f432_5c37;
	localparam int          MIX_SHIFT_A = 23;
	localparam int          MIX_SHIFT_B = 47;

	typedef struct packed {
		logic [63:0]            data_word;
		logic                   is_last;
		logic [63:0]            seed;
		logic [LEN_FIELD_W-1:0] total_length;
	} word_t;

	typedef struct packed {
		logic [63:0] hash_wide;
		logic [31:0] hash_narrow;
	} hash_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_LL,
		OP_MUL_LH,
		OP_MUL_HL,
		OP_SEED,
		OP_WORD,
		OP_ABSORB,
		OP_STORE,
		OP_FINPRE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   k_mix;
		logic   first;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic len_zero;
	} dp_stat_t;

endpackage

>>> rtl/fh64_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fh64_dp: fasthash64 datapath
// Operand, product and hash registers around one shared 32x32 multiplier.
// A 64-bit product modulo 2^64 is built from three partial products.
// ----------------------------------------------------------------------------
module fh64_dp import fh64_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic     clk,
	input  dp_cmd_t  cmd,
	input  word_t    word,
	output dp_stat_t stat,
	output hash_t    result
);

	localparam int LEN_W = (LENGTH_BITS < LEN_FIELD_W) ? LENGTH_BITS : LEN_FIELD_W;

	logic [63:0]      word_q;
	logic             last_q;
	logic [63:0]      seed_q;
	logic [2:0]       tail_q;
	logic [63:0]      x_q;
	logic [63:0]      p_q;
	logic [63:0]      hash_q;
	hash_t            result_q;

	logic [LEN_W-1:0] len_m;
	logic [63:0]      k;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [63:0]      prod;
	logic [31:0]      cross_sum;
	logic [63:0]      word_masked;
	logic [63:0]      final_mix;

	function automatic logic [63:0] premix(input logic [63:0] v);
		return v ^ (v >> MIX_SHIFT_A);
	endfunction

	function automatic logic [63:0] postmix(input logic [63:0] v);
		return v ^ (v >> MIX_SHIFT_B);
	endfunction

	// Only the low tail bytes of the last word count; a tail of zero keeps all.
	function automatic logic [63:0] mask_tail(input logic [63:0] w, input logic [2:0] tail);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (tail == 3'd0 || 3'(i) < tail) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return w & m;
	endfunction

	assign len_m = word.total_length[LEN_W-1:0];
	assign k     = cmd.k_mix ? MIX_MUL : HASH_MUL;
	assign mul_a = (cmd.op == OP_MUL_HL) ? x_q[63:32] : x_q[31:0];
	assign mul_b = (cmd.op == OP_MUL_LH) ? k[63:32] : k[31:0];
	assign prod  = mul_a * mul_b;
	assign cross_sum   = p_q[63:32] + prod[31:0];
	assign word_masked = last_q ? mask_tail(word_q, tail_q) : word_q;
	assign final_mix   = postmix(p_q);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				word_q <= word.data_word;
				last_q <= word.is_last;
				if (cmd.first) begin
					seed_q <= word.seed;
					tail_q <= len_m[2:0];
					x_q    <= 64'(len_m);
				end
			end
			OP_MUL_LL: p_q <= prod;
			OP_MUL_LH, OP_MUL_HL: p_q[63:32] <= cross_sum;
			OP_SEED: begin
				hash_q <= seed_q ^ p_q;
				x_q    <= premix(word_masked);
			end
			OP_WORD:   x_q <= premix(word_masked);
			OP_ABSORB: x_q <= hash_q ^ postmix(p_q);
			OP_STORE:  hash_q <= p_q;
			OP_FINPRE: x_q <= premix(hash_q);
			OP_OUT: begin
				result_q.hash_wide   <= final_mix;
				result_q.hash_narrow <= 32'(final_mix - (final_mix >> 32));
			end
			default: begin
			end
		endcase
	end

	// While the init steps run, x_q still holds the sampled length.
	assign stat.last     = last_q;
	assign stat.len_zero = (x_q == '0);
	assign result        = result_q;

endmodule

>>> rtl/fh64_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fh64_ctrl: fasthash64 sequencer
// Steps the datapath through init, word absorb and finalize, and owns the
// input stall and the result valid flag.
// ----------------------------------------------------------------------------
module fh64_ctrl import fh64_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     word_valid,
	output logic     word_stall,
	output logic     result_valid,
	input  logic     result_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT0, S_INIT1, S_SEED,
		S_WORD,
		S_MIX0, S_MIX1, S_MIX2,
		S_ABSORB,
		S_HM0, S_HM1, S_HM2,
		S_STORE,
		S_FINPRE,
		S_FM0, S_FM1, S_FM2,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_msg_q;
	logic   result_valid_q;
	logic   out_free;

	assign out_free   = !result_valid_q || !result_stall;
	assign word_stall = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd = '{op: OP_NOP, k_mix: 1'b0, first: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (word_valid) begin
					cmd.op    = OP_LOAD;
					cmd.first = !in_msg_q;
				end
			end
			S_INIT0:  cmd.op = OP_MUL_LL;
			S_INIT1:  cmd.op = OP_MUL_LH;
			S_SEED:   cmd.op = OP_SEED;
			S_WORD:   cmd.op = OP_WORD;
			S_MIX0:   cmd = '{op: OP_MUL_LL, k_mix: 1'b1, first: 1'b0};
			S_MIX1:   cmd = '{op: OP_MUL_LH, k_mix: 1'b1, first: 1'b0};
			S_MIX2:   cmd = '{op: OP_MUL_HL, k_mix: 1'b1, first: 1'b0};
			S_ABSORB: cmd.op = OP_ABSORB;
			S_HM0:    cmd.op = OP_MUL_LL;
			S_HM1:    cmd.op = OP_MUL_LH;
			S_HM2:    cmd.op = OP_MUL_HL;
			S_STORE:  cmd.op = OP_STORE;
			S_FINPRE: cmd.op = OP_FINPRE;
			S_FM0:    cmd = '{op: OP_MUL_LL, k_mix: 1'b1, first: 1'b0};
			S_FM1:    cmd = '{op: OP_MUL_LH, k_mix: 1'b1, first: 1'b0};
			S_FM2:    cmd = '{op: OP_MUL_HL, k_mix: 1'b1, first: 1'b0};
			S_OUT: begin
				if (out_free) begin
					cmd.op = OP_OUT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			in_msg_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// A new result loads in the same cycle the old one leaves.
			if (state_q == S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (word_valid) begin
						state_q <= in_msg_q ? S_WORD : S_INIT0;
					end
				end
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_SEED;
				S_SEED:  state_q <= stat.len_zero ? S_FINPRE : S_MIX0;
				S_WORD:  state_q <= S_MIX0;
				S_MIX0:  state_q <= S_MIX1;
				S_MIX1:  state_q <= S_MIX2;
				S_MIX2:  state_q <= S_ABSORB;
				S_ABSORB: state_q <= S_HM0;
				S_HM0:   state_q <= S_HM1;
				S_HM1:   state_q <= S_HM2;
				S_HM2:   state_q <= S_STORE;
				S_STORE: begin
					if (stat.last) begin
						state_q <= S_FINPRE;
					end else begin
						in_msg_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_FINPRE: state_q <= S_FM0;
				S_FM0:   state_q <= S_FM1;
				S_FM1:   state_q <= S_FM2;
				S_FM2:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						in_msg_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/fasthash64_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasthash64_stream: streaming fasthash64 over 64-bit little-endian words
// Absorbs one message word per transaction and returns the final 64-bit hash
// with its 32-bit fold once the word marked last has been absorbed.
// ----------------------------------------------------------------------------
// Each word is absorbed on the single shared 32x32 multiplier, which builds
// each 64-bit product in three steps (two for the 32-bit length product).
// The word marked last then runs finalization before its result is
// registered; a zero-length message goes straight from init to finalization.
// The input stays stalled until the block is idle again.
// Reset (arst_n low) is asynchronous: the block returns to idle, waiting for
// the first word of a message, with no result pending.
// ----------------------------------------------------------------------------
module fasthash64_stream import fh64_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  word_valid,
	output logic  word_stall,
	input  word_t word_data,
	output logic  result_valid,
	input  logic  result_stall,
	output hash_t result_data
);

	// The controller sequences the datapath over command and status structs
	// only. A transaction is taken only while the controller is idle, so the
	// datapath latches the word on the accepting edge and then works on its
	// own registers. The result register stays loaded until the downstream
	// side takes it, and the next input word is accepted meanwhile; only the
	// final load of a new result waits for the result register to free up.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	fh64_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	fh64_dp #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk    (clk),
		.cmd    (cmd),
		.word   (word_data),
		.stat   (stat),
		.result (result_data)
	);

	// An accepted word always keeps the block busy on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_stall |=> word_stall)
		else $error("input accepted on two consecutive cycles");

	// A new result is only produced from a finalize sequence, never from idle.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(word_stall))
		else $error("result appeared without a finalize sequence");

	// The narrow hash is always the fold of the wide hash it travels with.
	a_fold_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.hash_narrow == 32'(result_data.hash_wide
			- (result_data.hash_wide >> 32)))
		else $error("narrow hash does not match wide hash fold");

endmodule

>>> sim/fasthash64_stream_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasthash64_stream_test: self-checking bench for the streaming fasthash64
// Sends whole messages as word transactions and predicts each message hash
// with a local model of the hash chain. Every result transaction is checked
// field by field against the oldest predicted hash. Both sides idle at
// random, and the bench forces back-pressure and a full drain.
// ----------------------------------------------------------------------------
module fasthash64_stream_test;
	import fh64_pkg::*;

	// Stop feeding random messages once this many words are queued.
	localparam int WORD_TARGET = 1900;
	// Cycles with no transaction on either side before the run is declared hung.
	// The longest legal quiet spell is the receiver hold-off plus one message.
	localparam int IDLE_LIMIT = 3000;
	// Length of each forced receiver hold-off, in cycles.
	localparam int HOLD_CYCLES = 400;
	// Cycles to keep watching after the last hash, well past the block latency.
	localparam int TAIL_CYCLES = 60;

	// One queued input transaction: the payload, the idle cycles the sender
	// spends before offering it, and whether the sender must first see every
	// predicted hash arrive.
	typedef struct {
		word_t word;
		int    gap;
		bit    drain;
	} pending_word_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  word_valid = 1'b0;
	logic  word_stall;
	word_t word_data = '0;
	logic  result_valid;
	logic  result_stall = 1'b0;
	hash_t result_data;

	pending_word_t pending_words[$];
	hash_t         expected_hashes[$];

	// State of the local hash model.
	logic [63:0] chain_hash = '0;
	bit          msg_open = 1'b0;
	logic [2:0]  tail_len = '0;

	int words_queued = 0;
	int msgs_queued = 0;
	int empty_msgs = 0;
	int odd_count_msgs = 0;
	int hashes_checked = 0;
	int errors = 0;
	int idle_cycles = 0;
	int send_calm_left = 0;
	int recv_calm_left = 0;
	int recv_wait = 0;
	int hold_left = 0;

	fasthash64_stream uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.word_data    (word_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	always #5 clk = ~clk;

	// The fasthash mixing function: xorshift, multiply, xorshift, all mod 2^64.
	function automatic logic [63:0] mix_word(input logic [63:0] x);
		x = x ^ (x >> MIX_SHIFT_A);
		x = x * MIX_MUL;
		x = x ^ (x >> MIX_SHIFT_B);
		return x;
	endfunction

	// Advances the hash chain by one accepted word. Returns 1 and the final
	// hash when the word closes a message.
	function automatic bit absorb_word(input word_t w, output hash_t res);
		logic [63:0] data;
		bit          empty;
		data = w.data_word;
		empty = 1'b0;
		res = '0;
		// The first word of a message sets up the chain from seed and length.
		// A zero length makes this a dummy word that closes the message at once,
		// whatever its data and last flag say.
		if (!msg_open) begin
			chain_hash = w.seed ^ (64'(w.total_length) * HASH_MUL);
			tail_len = w.total_length[2:0];
			empty = (w.total_length == '0);
		end
		if (!empty) begin
			// Only the last word is trimmed to the tail bytes; any other word
			// counts in full even when the length says the message is over.
			if (w.is_last && tail_len != 3'd0)
				data = data & ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * tail_len));
			chain_hash = (chain_hash ^ mix_word(data)) * HASH_MUL;
			msg_open = !w.is_last;
		end
		if (empty || w.is_last) begin
			res.hash_wide = mix_word(chain_hash);
			res.hash_narrow = 32'(res.hash_wide - (res.hash_wide >> 32));
			msg_open = 1'b0;
			tail_len = '0;
			chain_hash = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Draws the idle cycles before the next transaction, with occasional calm
	// stretches of back-to-back transactions.
	function automatic int draw_wait(ref int calm_left);
		if (calm_left != 0) begin
			calm_left = calm_left - 1;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 4);
	endfunction

	// Queues one message of word_count words. The first word carries seed and
	// length; later words carry random seed and length, which the block must
	// ignore. A zero length queues one dummy word whose last flag is set only
	// when word_count is nonzero.
	task automatic queue_message(input logic [31:0] len, input int word_count,
			input logic [63:0] seed, input logic [63:0] data, input bit rand_data,
			input bit drain);
		pending_word_t item;
		int            n;
		n = (len == '0) ? 1 : word_count;
		for (int k = 0; k < n; k++) begin
			item.word.data_word = rand_data ? {$urandom, $urandom} : data;
			item.word.is_last = (len == '0) ? (word_count != 0) : (k == n - 1);
			item.word.seed = (k == 0) ? seed : {$urandom, $urandom};
			item.word.total_length = (k == 0) ? len : $urandom;
			item.gap = draw_wait(send_calm_left);
			item.drain = drain && (k == 0);
			pending_words.push_back(item);
			words_queued++;
		end
		msgs_queued++;
		if (len == '0)
			empty_msgs++;
		else if (longint'(word_count) != (longint'(len) + 7) / 8)
			odd_count_msgs++;
	endtask

	// Sender: offers queued words one after another, holds a stalled word
	// unchanged, and feeds every accepted word to the hash model.
	always @(posedge clk) begin
		hash_t res;
		if (!arst_n) begin
			word_valid <= 1'b0;
		end else begin
			if (word_valid && !word_stall) begin
				if (absorb_word(word_data, res))
					expected_hashes.push_back(res);
			end
			if (!(word_valid && word_stall)) begin
				if (pending_words.size() == 0) begin
					word_valid <= 1'b0;
				end else if (pending_words[0].gap != 0) begin
					pending_words[0].gap = pending_words[0].gap - 1;
					word_valid <= 1'b0;
				end else if (pending_words[0].drain && expected_hashes.size() != 0) begin
					// Pause here until the block has handed back every hash.
					word_valid <= 1'b0;
				end else begin
					word_data <= pending_words[0].word;
					word_valid <= 1'b1;
					void'(pending_words.pop_front());
				end
			end
		end
	end

	// Receiver: checks each result transaction against the oldest predicted
	// hash, then stalls for a random number of cycles. Twice during the run it
	// holds off for a long stretch so the block backs up and stalls its input.
	always @(posedge clk) begin
		hash_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_hashes.size() == 0) begin
					$display("%0t: unexpected hash, expected none, actual wide %h narrow %h",
						$time, result_data.hash_wide, result_data.hash_narrow);
					errors++;
				end else begin
					want = expected_hashes.pop_front();
					if (result_data.hash_wide !== want.hash_wide) begin
						$display("%0t: hash_wide mismatch, expected %h, actual %h",
							$time, want.hash_wide, result_data.hash_wide);
						errors++;
					end
					if (result_data.hash_narrow !== want.hash_narrow) begin
						$display("%0t: hash_narrow mismatch, expected %h, actual %h",
							$time, want.hash_narrow, result_data.hash_narrow);
						errors++;
					end
				end
				hashes_checked++;
				if (hashes_checked == 100 || hashes_checked == 300)
					hold_left = HOLD_CYCLES;
				recv_wait = draw_wait(recv_calm_left);
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (recv_wait != 0) begin
				recv_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a long spell with no transaction on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((word_valid && !word_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d hashes outstanding",
					$time, IDLE_LIMIT, expected_hashes.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int          pick;
		int          n;
		logic [31:0] len;
		bit          drain;

		// Directed messages: empty messages with either last flag, single-word
		// messages at full and partial tails, the largest length, seed and
		// length changes inside a message, and word counts that disagree with
		// the length in both directions.
		queue_message(32'd0, 0, 64'd0, '1, 1'b0, 1'b0);
		queue_message(32'd0, 1, '1, '1, 1'b0, 1'b0);
		queue_message(32'd8, 1, 64'd0, '1, 1'b0, 1'b0);
		queue_message(32'd1, 1, '1, '1, 1'b0, 1'b0);
		queue_message(32'd7, 1, {$urandom, $urandom}, '1, 1'b0, 1'b0);
		queue_message(32'hFFFF_FFFF, 1, '1, '1, 1'b0, 1'b0);
		queue_message(32'd9, 2, '1, '1, 1'b0, 1'b0);
		queue_message(32'd16, 3, 64'd0, 64'd0, 1'b0, 1'b0);
		queue_message(32'd24, 1, {$urandom, $urandom}, '0, 1'b1, 1'b0);
		queue_message(32'd13, 2, {$urandom, $urandom}, '0, 1'b1, 1'b0);
		queue_message(32'd5, 4, {$urandom, $urandom}, '0, 1'b1, 1'b0);

		// Random messages, mostly well formed. The first one waits until the
		// directed hashes are all back; a few later ones do the same.
		drain = 1'b1;
		while (words_queued < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				len = 32'd0;
				n = $urandom_range(0, 1);
			end else if (pick < 45) begin
				len = $urandom_range(1, 8);
				n = 1;
			end else if (pick < 75) begin
				len = $urandom_range(9, 64);
				n = (len + 7) / 8;
			end else if (pick < 85) begin
				len = $urandom_range(65, 256);
				n = (len + 7) / 8;
			end else begin
				// Any nonzero 32-bit length with a short, unrelated word count.
				len = $urandom;
				if (len == '0)
					len = 32'd1;
				n = $urandom_range(1, 6);
			end
			queue_message(len, n, {$urandom, $urandom}, '0, 1'b1, drain);
			drain = ($urandom_range(0, 99) == 0);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every word is taken and every hash is back, then watch a
		// while longer for stray results.
		do
			@(posedge clk);
		while (pending_words.size() != 0 || word_valid || expected_hashes.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d words in %0d messages: %0d empty, %0d with a word count",
			words_queued, msgs_queued, empty_msgs, odd_count_msgs);
		$display("that disagrees with the length; %0d hashes checked, %0d errors.",
			hashes_checked, errors);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
